// ===== rtl/core/ptc_pkg.sv =====
// Shared constants and types for the pressure/temperature compensation pipeline.
package ptc_pkg;

    localparam int RAW_W      = 24;
    localparam int RES_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int NST        = 11;     // pipeline stages

    localparam int T_REF      = 2000;
    localparam int T_VLOW     = -1500;
    localparam int SH_TEMP    = 23;
    localparam int SH_PROD    = 21;
    localparam int SH_P_2BAR  = 15;
    localparam int SH_P_30BAR = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS     = 3'd0,
        CFG_OFFSET   = 3'd1,
        CFG_SENS_TC  = 3'd2,
        CFG_OFF_TC   = 3'd3,
        CFG_REF_TEMP = 3'd4,
        CFG_TEMP_TC  = 3'd5,
        CFG_VARIANT  = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        VAR_2BAR  = 1'b0,
        VAR_30BAR = 1'b1
    } t_variant;

endpackage

// ===== rtl/core/ptc_in_if.sv =====
// Input channel: one raw pressure / temperature conversion pair per item.
interface ptc_in_if;
    import ptc_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ===== rtl/core/ptc_out_if.sv =====
// Output channel: compensated pressure and temperature per item.
interface ptc_out_if;
    import ptc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] pressure;
    logic signed [RES_W-1:0] temperature;

    modport source (output valid, output pressure, output temperature, input ready);
    modport sink   (input valid, input pressure, input temperature, output ready);
endinterface

// ===== rtl/core/pressure_temp_compensation.sv =====
// Pipelined second-order pressure/temperature compensation, top level.
//
//  channel   dir  payload                            handshake
//  i_in      in   raw_pressure, raw_temperature      valid/ready
//  o_out     out  pressure, temperature              valid/ready
//  i_cfg_*   in   i_cfg_idx, i_cfg_data              i_cfg_we, no wait
//
//  One item per cycle through eleven stages while o_out.ready keeps the pipe moving;
//  each item passes stage registers 1 to 11 in order, and o_out.valid is stage 11's valid bit.
//  The depth is set by the chain dT -> products -> squares -> corrections
//  -> split D1 product -> two truncating shifts.
//  Each stage loads when empty or when the stage after it moves, so bubbles close up.
//  Synchronous reset clears the valid bits and the calibration registers.
module pressure_temp_compensation (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ptc_in_if.sink                           i_in,
    ptc_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ptc_pkg::*;

    localparam logic signed [41:0] B_T    = (42'sd1 <<< SH_TEMP) - 42'sd1;
    localparam logic signed [41:0] B_6    = (42'sd1 <<< 6) - 42'sd1;
    localparam logic signed [41:0] B_7    = (42'sd1 <<< 7) - 42'sd1;
    localparam logic signed [41:0] B_8    = (42'sd1 <<< 8) - 42'sd1;
    localparam logic signed [63:0] B_PROD = (64'sd1 <<< SH_PROD) - 64'sd1;
    localparam logic signed [43:0] B_P2   = (44'sd1 <<< SH_P_2BAR) - 44'sd1;
    localparam logic signed [43:0] B_P30  = (44'sd1 <<< SH_P_30BAR) - 44'sd1;
    localparam logic signed [43:0] P_MAX  = 44'sd2147483647;
    localparam logic signed [43:0] P_MIN  = -44'sd2147483648;
    localparam logic signed [18:0] V_OFS  = 19'(T_REF - T_VLOW);
    localparam logic signed [17:0] Q_VLOW = 18'(T_VLOW - T_REF);
    localparam logic signed [19:0] TREF20 = 20'(T_REF);

    // calibration words C1..C6 and variant
    logic [CFG_DATA_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    t_variant              r_variant;
    logic                  w_v0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1      <= '0;
            r_c2      <= '0;
            r_c3      <= '0;
            r_c4      <= '0;
            r_c5      <= '0;
            r_c6      <= '0;
            r_variant <= VAR_2BAR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SENS:     r_c1 <= i_cfg_data;
                CFG_OFFSET:   r_c2 <= i_cfg_data;
                CFG_SENS_TC:  r_c3 <= i_cfg_data;
                CFG_OFF_TC:   r_c4 <= i_cfg_data;
                CFG_REF_TEMP: r_c5 <= i_cfg_data;
                CFG_TEMP_TC:  r_c6 <= i_cfg_data;
                CFG_VARIANT:  r_variant <= t_variant'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    assign w_v0 = (r_variant == VAR_2BAR);

    // stage control
    logic [NST:1]   r_vld;
    logic [NST+1:1] w_en;
    logic           w_in_acc, w_out_acc;

    always_comb begin
        w_en[NST+1] = o_out.ready;
        for (int k = NST; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready = w_en[1];
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = o_out.valid && o_out.ready;

    // stage 1: dT
    logic [RAW_W-1:0]  r1_d1;
    logic signed [24:0] r1_dt, n1_dt;

    assign n1_dt = $signed({1'b0, i_in.raw_temperature}) - $signed({1'b0, r_c5, 8'b0});

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_d1 <= i_in.raw_pressure;
            r1_dt <= n1_dt;
        end
    end

    // stage 2: dT products
    logic [RAW_W-1:0]   r2_d1;
    logic signed [41:0] r2_pt, r2_po, r2_ps, n2_pt, n2_po, n2_ps;
    logic signed [49:0] n2_dtsq;
    logic [47:0]        r2_dt2;

    assign n2_pt   = r1_dt * $signed({1'b0, r_c6});
    assign n2_po   = r1_dt * $signed({1'b0, r_c4});
    assign n2_ps   = r1_dt * $signed({1'b0, r_c3});
    assign n2_dtsq = r1_dt * r1_dt;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_d1  <= r1_d1;
            r2_pt  <= n2_pt;
            r2_po  <= n2_po;
            r2_ps  <= n2_ps;
            r2_dt2 <= n2_dtsq[47:0];
        end
    end

    // stage 3: TEMP offset, OFF, SENS, Ti candidates
    logic [RAW_W-1:0]   r3_d1;
    logic signed [17:0] r3_q, n3_q;
    logic signed [37:0] r3_off, r3_sens, n3_off, n3_sens;
    logic [16:0]        r3_ti_lo, r3_ti_hi, n3_ti_lo, n3_ti_hi;
    logic signed [41:0] w3_po6, w3_po7, w3_ps7, w3_ps8;
    logic [51:0]        w3_m11;
    logic [49:0]        w3_m3;

    always_comb begin
        n3_q   = 18'((r2_pt + (r2_pt[41] ? B_T : 42'sd0)) >>> SH_TEMP);
        w3_po6 = (r2_po + (r2_po[41] ? B_6 : 42'sd0)) >>> 6;
        w3_po7 = (r2_po + (r2_po[41] ? B_7 : 42'sd0)) >>> 7;
        w3_ps7 = (r2_ps + (r2_ps[41] ? B_7 : 42'sd0)) >>> 7;
        w3_ps8 = (r2_ps + (r2_ps[41] ? B_8 : 42'sd0)) >>> 8;
        w3_m11 = {4'b0, r2_dt2} + {3'b0, r2_dt2, 1'b0} + {1'b0, r2_dt2, 3'b0};
        w3_m3  = {2'b0, r2_dt2} + {1'b0, r2_dt2, 1'b0};
        if (w_v0) begin
            n3_off   = 38'(w3_po6 + $signed({9'b0, r_c2, 17'b0}));
            n3_sens  = 38'(w3_ps7 + $signed({10'b0, r_c1, 16'b0}));
            n3_ti_lo = w3_m11[51:35];
            n3_ti_hi = 17'd0;
        end else begin
            n3_off   = 38'(w3_po7 + $signed({10'b0, r_c2, 16'b0}));
            n3_sens  = 38'(w3_ps8 + $signed({11'b0, r_c1, 15'b0}));
            n3_ti_lo = w3_m3[49:33];
            n3_ti_hi = {5'b0, r2_dt2[47:36]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_d1    <= r2_d1;
            r3_q     <= n3_q;
            r3_off   <= n3_off;
            r3_sens  <= n3_sens;
            r3_ti_lo <= n3_ti_lo;
            r3_ti_hi <= n3_ti_hi;
        end
    end

    // stage 4: squares, temperature result
    logic [RAW_W-1:0]   r4_d1;
    logic signed [37:0] r4_off, r4_sens;
    logic [34:0]        r4_sq, r4_vsq;
    logic               r4_low, r4_vlow;
    logic signed [19:0] r4_temp, n4_temp;
    logic signed [18:0] w4_v;
    logic signed [35:0] w4_sq;
    logic signed [37:0] w4_vsq;
    logic [16:0]        w4_ti;

    always_comb begin
        w4_v    = $signed({r3_q[17], r3_q}) + V_OFS;
        w4_sq   = r3_q * r3_q;
        w4_vsq  = w4_v * w4_v;
        w4_ti   = r3_q[17] ? r3_ti_lo : r3_ti_hi;
        n4_temp = $signed({{2{r3_q[17]}}, r3_q}) + TREF20 - $signed({3'b0, w4_ti});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_d1   <= r3_d1;
            r4_off  <= r3_off;
            r4_sens <= r3_sens;
            r4_sq   <= w4_sq[34:0];
            r4_vsq  <= w4_vsq[34:0];
            r4_low  <= r3_q[17];
            r4_vlow <= (r3_q < Q_VLOW);
            r4_temp <= n4_temp;
        end
    end

    // stage 5: second-order corrections
    logic [RAW_W-1:0]   r5_d1;
    logic signed [37:0] r5_off, r5_sens;
    logic signed [19:0] r5_temp;
    logic [38:0]        r5_offi, r5_sensi, n5_offi, n5_sensi;
    logic [39:0]        w5_o31;
    logic [40:0]        w5_s63;
    logic [35:0]        w5_o3;
    logic [36:0]        w5_s5, w5_v4;
    logic [37:0]        w5_v7;

    always_comb begin
        w5_o31   = {r4_sq, 5'b0} - {5'b0, r4_sq};
        w5_s63   = {r4_sq, 6'b0} - {6'b0, r4_sq};
        w5_o3    = {r4_sq, 1'b0} + {1'b0, r4_sq};
        w5_s5    = {r4_sq, 2'b0} + {2'b0, r4_sq};
        w5_v7    = {r4_vsq, 3'b0} - {3'b0, r4_vsq};
        w5_v4    = {r4_vsq, 2'b0};
        n5_offi  = '0;
        n5_sensi = '0;
        if (w_v0) begin
            if (r4_low) begin
                n5_offi  = 39'(w5_o31[39:3]);
                n5_sensi = 39'(w5_s63[40:5]);
            end
        end else if (r4_low) begin
            n5_offi  = 39'(w5_o3[35:1]) + (r4_vlow ? 39'(w5_v7) : 39'd0);
            n5_sensi = 39'(w5_s5[36:3]) + (r4_vlow ? 39'(w5_v4) : 39'd0);
        end else begin
            n5_offi  = 39'(r4_sq[34:4]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_d1    <= r4_d1;
            r5_off   <= r4_off;
            r5_sens  <= r4_sens;
            r5_temp  <= r4_temp;
            r5_offi  <= n5_offi;
            r5_sensi <= n5_sensi;
        end
    end

    // stage 6: corrected SENS and OFF
    logic [RAW_W-1:0]   r6_d1;
    logic signed [40:0] r6_diff, r6_offd, n6_diff, n6_offd;
    logic signed [19:0] r6_temp;

    assign n6_diff = $signed({{3{r5_sens[37]}}, r5_sens}) - $signed({2'b0, r5_sensi});
    assign n6_offd = $signed({{3{r5_off[37]}}, r5_off}) - $signed({2'b0, r5_offi});

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_d1   <= r5_d1;
            r6_diff <= n6_diff;
            r6_offd <= n6_offd;
            r6_temp <= r5_temp;
        end
    end

    // stage 7: D1 * SENS as two partial products
    logic [43:0]        r7_pl, n7_pl;
    logic signed [45:0] r7_ph, n7_ph;
    logic signed [40:0] r7_offd;
    logic signed [19:0] r7_temp;

    assign n7_pl = r6_d1 * r6_diff[19:0];
    assign n7_ph = $signed({1'b0, r6_d1}) * $signed(r6_diff[40:20]);

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_pl   <= n7_pl;
            r7_ph   <= n7_ph;
            r7_offd <= r6_offd;
            r7_temp <= r6_temp;
        end
    end

    // stage 8: recombine
    logic signed [63:0] r8_prod, n8_prod;
    logic signed [40:0] r8_offd;
    logic signed [19:0] r8_temp;

    assign n8_prod = $signed({r7_ph[43:0], 20'b0}) + $signed({20'b0, r7_pl});

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r8_prod <= n8_prod;
            r8_offd <= r7_offd;
            r8_temp <= r7_temp;
        end
    end

    // stage 9: product / 2^21, toward zero
    logic signed [42:0] r9_t, n9_t;
    logic signed [40:0] r9_offd;
    logic signed [19:0] r9_temp;

    assign n9_t = 43'((r8_prod + (r8_prod[63] ? B_PROD : 64'sd0)) >>> SH_PROD);

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r9_t    <= n9_t;
            r9_offd <= r8_offd;
            r9_temp <= r8_temp;
        end
    end

    // stage 10: subtract offset
    logic signed [43:0] r10_a, n10_a;
    logic signed [19:0] r10_temp;

    assign n10_a = $signed({r9_t[42], r9_t}) - $signed({{3{r9_offd[40]}}, r9_offd});

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            r10_a    <= n10_a;
            r10_temp <= r9_temp;
        end
    end

    // stage 11: variant scaling, saturate
    logic signed [RES_W-1:0] r11_pres, n11_pres;
    logic signed [19:0]      r11_temp;
    logic signed [43:0]      w11_rnd, w11_sh;

    always_comb begin
        w11_rnd = r10_a + (r10_a[43] ? (w_v0 ? B_P2 : B_P30) : 44'sd0);
        w11_sh  = w_v0 ? (w11_rnd >>> SH_P_2BAR) : (w11_rnd >>> SH_P_30BAR);
        if (w11_sh > P_MAX) begin
            n11_pres = 32'(P_MAX);
        end else if (w11_sh < P_MIN) begin
            n11_pres = 32'(P_MIN);
        end else begin
            n11_pres = 32'(w11_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[11]) begin
            r11_pres <= n11_pres;
            r11_temp <= r10_temp;
        end
    end

    // temperature stays well inside 20 bits, so no clamp is needed
    assign o_out.valid       = r_vld[NST];
    assign o_out.pressure    = r11_pres;
    assign o_out.temperature = {{(RES_W-20){r11_temp[19]}}, r11_temp};

    a_fill_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_out_acc) |=> ($countones(r_vld) == $past($countones(r_vld)) + 1))
        else $error("item count did not grow on accept");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !w_in_acc) |=> ($countones(r_vld) == $past($countones(r_vld)) - 1))
        else $error("item count did not fall on delivery");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while pipeline full and stalled");

    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[6] && !w_en[6]) |=> (r_vld[6] && $stable(r6_diff) && $stable(r6_offd)))
        else $error("stalled stage lost its item");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.temperature[RES_W-1:19] == {(RES_W-19){o_out.temperature[RES_W-1]}}))
        else $error("temperature outside expected range");

endmodule

// ===== tb/tb_pressure_temp_compensation.sv =====
// Self-checking testbench for the pressure/temperature compensation pipeline.
`timescale 1ns / 1ps

module tb_pressure_temp_compensation;
    import ptc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = NST + 8;
    localparam int IDLE_PCT    = 17;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 55;
    localparam int STALL_LEN   = 120;
    localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED = 3'd7;
    localparam logic [RAW_W-1:0]      RAW_MAX    = {RAW_W{1'b1}};
    localparam logic [CFG_DATA_W-1:0] COEFF_MAX  = {CFG_DATA_W{1'b1}};
    localparam longint RES_MAX = (longint'(1) <<< (RES_W - 1)) - 1;
    localparam longint RES_MIN = -(longint'(1) <<< (RES_W - 1));

    typedef struct packed {
        logic signed [RES_W-1:0] pressure;
        logic signed [RES_W-1:0] temperature;
    } t_comp_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ptc_in_if  in_ch ();
    ptc_out_if out_ch ();

    pressure_temp_compensation DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // calibration as the block should hold it
    logic [CFG_DATA_W-1:0] cal_sens;
    logic [CFG_DATA_W-1:0] cal_offset;
    logic [CFG_DATA_W-1:0] cal_sens_tc;
    logic [CFG_DATA_W-1:0] cal_off_tc;
    logic [CFG_DATA_W-1:0] cal_ref_temp;
    logic [CFG_DATA_W-1:0] cal_temp_tc;
    t_variant              cal_variant;

    t_comp_result pending_results[$];
    int src_idle_pct;
    int sink_idle_pct;
    int sink_hold_req;
    int sink_hold_left;
    int err_count;
    int items_sent;
    int results_checked;
    int cal_loads;
    int cycle_count;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint pow2(int k);
        return longint'(1) <<< k;
    endfunction

    function automatic logic signed [RES_W-1:0] sat_res(longint v);
        if (v > RES_MAX) v = RES_MAX;
        if (v < RES_MIN) v = RES_MIN;
        return v[RES_W-1:0];
    endfunction

    function automatic t_comp_result compensate(input logic [RAW_W-1:0] raw_p,
                                                input logic [RAW_W-1:0] raw_t);
        longint d1, d2, dt, temp, dtmp_sq, off, sens, ti, offi, sensi, vlow, pres;
        int p_shift;
        t_comp_result res;
        d1 = raw_p;
        d2 = raw_t;
        dt = d2 - longint'(cal_ref_temp) * 256;
        temp = T_REF + (dt * longint'(cal_temp_tc)) / pow2(SH_TEMP);
        dtmp_sq = (temp - T_REF) * (temp - T_REF);
        if (cal_variant == VAR_2BAR) begin
            off  = longint'(cal_offset) * pow2(17) + (longint'(cal_off_tc) * dt) / pow2(6);
            sens = longint'(cal_sens) * pow2(16) + (longint'(cal_sens_tc) * dt) / pow2(7);
            p_shift = SH_P_2BAR;
            if (temp < T_REF) begin
                ti    = (11 * dt * dt) / pow2(35);
                offi  = (31 * dtmp_sq) / pow2(3);
                sensi = (63 * dtmp_sq) / pow2(5);
            end else begin
                ti    = 0;
                offi  = 0;
                sensi = 0;
            end
        end else begin
            off  = longint'(cal_offset) * pow2(16) + (longint'(cal_off_tc) * dt) / pow2(7);
            sens = longint'(cal_sens) * pow2(15) + (longint'(cal_sens_tc) * dt) / pow2(8);
            p_shift = SH_P_30BAR;
            if (temp < T_REF) begin
                ti    = (3 * dt * dt) / pow2(33);
                offi  = (3 * dtmp_sq) / 2;
                sensi = (5 * dtmp_sq) / pow2(3);
                if (temp < T_VLOW) begin
                    vlow  = temp - T_VLOW;
                    offi  = offi + 7 * vlow * vlow;
                    sensi = sensi + 4 * vlow * vlow;
                end
            end else begin
                ti    = (2 * dt * dt) / pow2(37);
                offi  = dtmp_sq / pow2(4);
                sensi = 0;
            end
        end
        pres = ((d1 * (sens - sensi)) / pow2(SH_PROD) - (off - offi)) / pow2(p_shift);
        res.pressure    = sat_res(pres);
        res.temperature = sat_res(temp - ti);
        return res;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_coeff();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return COEFF_MAX;
        return CFG_DATA_W'($urandom_range(COEFF_MAX));
    endfunction

    function automatic logic [RAW_W-1:0] ref_point();
        return {cal_ref_temp, 8'h00};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SENS:     cal_sens     = data;
            CFG_OFFSET:   cal_offset   = data;
            CFG_SENS_TC:  cal_sens_tc  = data;
            CFG_OFF_TC:   cal_off_tc   = data;
            CFG_REF_TEMP: cal_ref_temp = data;
            CFG_TEMP_TC:  cal_temp_tc  = data;
            CFG_VARIANT:  cal_variant  = t_variant'(data[0]);
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_calibration(input logic [CFG_DATA_W-1:0] c1, c2, c3, c4, c5, c6,
                                    input t_variant var_sel);
        write_reg(CFG_SENS, c1);
        write_reg(CFG_OFFSET, c2);
        write_reg(CFG_SENS_TC, c3);
        write_reg(CFG_OFF_TC, c4);
        write_reg(CFG_REF_TEMP, c5);
        write_reg(CFG_TEMP_TC, c6);
        write_reg(CFG_VARIANT, {{(CFG_DATA_W-1){1'b0}}, var_sel});
        cfg_close();
        cal_loads++;
    endtask

    task automatic send_sample(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.raw_pressure    <= raw_p;
        in_ch.raw_temperature <= raw_t;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_results.push_back(compensate(raw_p, raw_t));
        items_sent++;
    endtask

    // temperatures half near the reference point, half across the full range
    task automatic send_random_sample();
        logic [RAW_W-1:0] raw_p, raw_t;
        int r, near;
        r = $urandom_range(9);
        if (r == 0) raw_p = '0;
        else if (r == 1) raw_p = RAW_MAX;
        else raw_p = RAW_W'($urandom_range(RAW_MAX));
        if ($urandom_range(1)) begin
            raw_t = RAW_W'($urandom_range(RAW_MAX));
        end else begin
            near = int'(ref_point()) + int'($urandom_range(1 << 21)) - (1 << 20);
            if (near < 0) near = 0;
            if (near > int'(RAW_MAX)) near = int'(RAW_MAX);
            raw_t = near[RAW_W-1:0];
        end
        send_sample(raw_p, raw_t);
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        wait_results_drained();
    endtask

    task automatic test_2bar_directed();
        load_calibration(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146,
                         VAR_2BAR);
        send_sample(24'd4958179, 24'd6815414);
        send_sample('0, ref_point());
        // one below the reference truncates back to exactly 2000
        send_sample(RAW_MAX, ref_point() - 24'd1);
        send_sample(RAW_MAX, '0);
        send_sample('0, RAW_MAX);
        send_sample(RAW_MAX, RAW_MAX);
        wait_results_drained();
    endtask

    task automatic test_coeff_extremes();
        load_calibration(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX,
                         VAR_2BAR);
        send_sample(RAW_MAX, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, '0);
        wait_results_drained();
        load_calibration(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX,
                         VAR_30BAR);
        send_sample(RAW_MAX, '0);
        send_sample(RAW_MAX, RAW_MAX);
        wait_results_drained();
    endtask

    task automatic test_30bar_directed();
        load_calibration(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165,
                         VAR_30BAR);
        send_sample(24'd6465444, 24'd8077636);
        send_sample(RAW_MAX, '0);
        send_sample(24'h400000, ref_point() - 24'h080000);
        send_sample(RAW_MAX, ref_point() - 24'h100000);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(24'd123456, ref_point());
        wait_results_drained();
    endtask

    // unused index is dropped, variant takes bit 0 only
    task automatic test_register_decode();
        write_reg(CFG_UNUSED, COEFF_MAX);
        write_reg(CFG_VARIANT, 16'hFFFE);
        cfg_close();
        send_sample(24'd6465444, 24'd8077636);
        send_sample(RAW_MAX, '0);
        wait_results_drained();
        write_reg(CFG_VARIANT, 16'h0003);
        cfg_close();
        send_sample(24'd6465444, '0);
        wait_results_drained();
    endtask

    task automatic test_random_calibrations();
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            load_calibration(random_coeff(), random_coeff(), random_coeff(), random_coeff(),
                             random_coeff(), random_coeff(), t_variant'(ph[0]));
            repeat (PHASE_ITEMS) send_random_sample();
            wait_results_drained();
        end
    endtask

    task automatic test_no_idle_stretch();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (120) send_random_sample();
        wait_results_drained();
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
    endtask

    // long sink hold fills the pipe; then the sender waits for every result
    task automatic test_output_backpressure();
        load_calibration(random_coeff(), random_coeff(), random_coeff(), random_coeff(),
                         random_coeff(), random_coeff(), VAR_30BAR);
        src_idle_pct  = 0;
        sink_hold_req = STALL_LEN;
        repeat (40) send_random_sample();
        wait_results_drained();
        src_idle_pct = IDLE_PCT;
        repeat (20) send_random_sample();
        wait_results_drained();
    endtask

    initial begin : result_sink
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req > 0) begin
                sink_hold_left = sink_hold_req;
                sink_hold_req  = 0;
            end
            if (sink_hold_left > 0) begin
                sink_hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_comp_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result pressure=%0d temperature=%0d",
                         $time, out_ch.pressure, out_ch.temperature);
            end else begin
                want = pending_results.pop_front();
                if (want.pressure !== out_ch.pressure) begin
                    err_count++;
                    $display("%0t: pressure expected %0d actual %0d",
                             $time, want.pressure, out_ch.pressure);
                end
                if (want.temperature !== out_ch.temperature) begin
                    err_count++;
                    $display("%0t: temperature expected %0d actual %0d",
                             $time, want.temperature, out_ch.temperature);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("FAIL pressure_temp_compensation");
            $finish;
        end
    end

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= CFG_SENS;
        i_cfg_data            <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.raw_pressure    <= '0;
        in_ch.raw_temperature <= '0;
        cal_sens        = '0;
        cal_offset      = '0;
        cal_sens_tc     = '0;
        cal_off_tc      = '0;
        cal_ref_temp    = '0;
        cal_temp_tc     = '0;
        cal_variant     = VAR_2BAR;
        src_idle_pct    = IDLE_PCT;
        sink_idle_pct   = IDLE_PCT;
        sink_hold_req   = 0;
        sink_hold_left  = 0;
        err_count       = 0;
        items_sent      = 0;
        results_checked = 0;
        cal_loads       = 0;
        cycle_count     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_2bar_directed();
        test_coeff_extremes();
        test_30bar_directed();
        test_register_decode();
        test_random_calibrations();
        test_no_idle_stretch();
        test_output_backpressure();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Sent %0d items over %0d calibrations, both variants, all temperature ranges.",
                 items_sent, cal_loads);
        $display("Checked %0d results under random and long output stalls, %0d mismatches.",
                 results_checked, err_count);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("PASS pressure_temp_compensation");
        end else begin
            $display("FAIL pressure_temp_compensation");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ptc_pkg.sv
rtl/core/ptc_in_if.sv
rtl/core/ptc_out_if.sv
rtl/core/pressure_temp_compensation.sv
tb/tb_pressure_temp_compensation.sv
